// File: rtl/core/vgs_pkg.sv
// Shared types, codes and lookup tables for the display grid scan serializer.
`default_nettype none

package vgs_pkg;

  // Number of display grids scanned in turn
  localparam int unsigned GridCount = 7;

  // Digit code that shows an empty grid
  localparam logic [3:0] DigitBlank = 4'ha;

  // Fixed high byte of every grid word
  localparam logic [7:0] WordTopByte = 8'h02;

  // Top byte held in the word register at reset; the first word build replaces it before any byte is sent
  localparam logic [7:0] ResetTopByte = 8'h03;

  // Request codes carried in the mode field
  typedef enum logic [1:0] {
    ModeTick  = 2'd0,
    ModeDigit = 2'd1,
    ModeSym   = 2'd2,
    ModeBlank = 2'd3
  } mode_e;

  // Input beat
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] position;
    logic [3:0] digit;
    logic [2:0] symbol;
  } in_t;

  // Result beat
  typedef struct packed {
    logic data_pin;
    logic shift_clock;
    logic latch_clock;
    logic clear_line;
    logic write_error;
  } out_t;

  // Driven pin levels
  typedef struct packed {
    logic clear;
    logic latch;
    logic sclk;
    logic data;
  } pins_t;

  // Segment pattern, low byte; blank above nine
  function automatic logic [7:0] seg_lo(input logic [3:0] d);
    logic [7:0] r;
    unique case (d)
      4'd0:    r = 8'h6d;
      4'd1:    r = 8'h28;
      4'd2:    r = 8'h65;
      4'd3:    r = 8'h6c;
      4'd4:    r = 8'h28;
      4'd5:    r = 8'h4c;
      4'd6:    r = 8'h4d;
      4'd7:    r = 8'h68;
      4'd8:    r = 8'h6d;
      4'd9:    r = 8'h6c;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Segment pattern, high byte; blank above nine
  function automatic logic [7:0] seg_hi(input logic [3:0] d);
    logic [7:0] r;
    unique case (d)
      4'd0:    r = 8'h80;
      4'd2,
      4'd3:    r = 8'h20;
      4'd4,
      4'd5,
      4'd6,
      4'd8,
      4'd9:    r = 8'ha0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte that holds a grid's select bit
  function automatic logic [1:0] grid_byte(input logic [2:0] g);
    logic [1:0] r;
    unique case (g)
      3'd0, 3'd1:       r = 2'd2;
      3'd2, 3'd3, 3'd4: r = 2'd1;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // Mask of a grid's select bit
  function automatic logic [7:0] grid_mask(input logic [2:0] g);
    logic [7:0] r;
    unique case (g)
      3'd0:    r = 8'h04;
      3'd1:    r = 8'h20;
      3'd2:    r = 8'h01;
      3'd3:    r = 8'h10;
      3'd4:    r = 8'h40;
      3'd5:    r = 8'h02;
      default: r = 8'h10;
    endcase
    return r;
  endfunction

  // Symbol table: target byte
  function automatic logic [1:0] sym_byte(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd2:    r = 2'd1;
      3'd7:    r = 2'd0;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Symbol table: grid that shows the symbol
  function automatic logic [2:0] sym_grid(input logic [2:0] s);
    logic [2:0] r;
    unique case (s)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd0;
      3'd3:    r = 3'd3;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  // Symbol table: bits set in the target byte
  function automatic logic [7:0] sym_bits(input logic [2:0] s);
    logic [7:0] r;
    unique case (s)
      3'd0:    r = 8'h80;
      3'd1:    r = 8'h40;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h08;
      3'd4:    r = 8'h02;
      3'd5:    r = 8'h01;
      3'd6:    r = 8'h08;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vfd_grid_scan_serializer.sv
// Latency: a result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; every request is a single table lookup and
// state update done between the input handshake and the result register.
// Input ready drops only while a result is held and the sink is stalled.
// Reset (async, active low): scan at word build, digits blank, symbols clear,
// clear line high, other pins low, no result pending.
`default_nettype none

module vfd_grid_scan_serializer #(
  parameter int unsigned GridCount = vgs_pkg::GridCount,
  localparam int unsigned GridW = $clog2(GridCount)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire vgs_pkg::in_t in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output vgs_pkg::out_t    out_data_o
);

  typedef enum logic [2:0] {
    PhBuild = 3'd0,
    PhClear = 3'd1,
    PhLoad  = 3'd2,
    PhClkLo = 3'd3,
    PhClkHi = 3'd4,
    PhLatch = 3'd5
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [GridCount-1:0][3:0]      digits_q, digits_d;
  logic [GridCount-1:0][1:0]      sym_sel_q, sym_sel_d;
  logic [GridCount-1:0][7:0]      sym_bits_q, sym_bits_d;
  logic [3:0][7:0]                word_q, word_d;
  logic [7:0]                     shift_q, shift_d;
  logic [3:0]                     bits_q, bits_d;
  logic [1:0]                     ptr_q, ptr_d;
  logic [GridW-1:0]               grid_q, grid_d;
  vgs_pkg::pins_t                 pins_q, pins_d;
  logic                           out_valid_q, out_valid_d;
  vgs_pkg::out_t                  out_q, out_d;

  logic                           accept;
  logic                           err;
  logic [GridW-1:0]               g;
  logic [3:0][7:0]                built;
  logic [2:0]                     sg;

  // Take a beat whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Wrap an out-of-range grid index back to the first grid
  assign g  = (grid_q >= GridW'(GridCount)) ? '0 : grid_q;
  assign sg = vgs_pkg::sym_grid(in_data_i.symbol);

  vgs_word_build #(
    .GridCount(GridCount)
  ) u_word_build (
    .grid_i    (g),
    .digit_i   (digits_q[g]),
    .sym_sel_i (sym_sel_q[g]),
    .sym_bits_i(sym_bits_q[g]),
    .word_o    (built)
  );

  // Next state of the sequencer and the display stores
  always_comb begin
    phase_d    = phase_q;
    digits_d   = digits_q;
    sym_sel_d  = sym_sel_q;
    sym_bits_d = sym_bits_q;
    word_d     = word_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    ptr_d      = ptr_q;
    grid_d     = grid_q;
    pins_d     = pins_q;
    err        = 1'b0;
    if (accept) begin
      unique case (vgs_pkg::mode_e'(in_data_i.mode))
        vgs_pkg::ModeTick: begin
          unique case (phase_q)
            PhClear: begin
              pins_d.clear = 1'b1;
              phase_d      = PhLoad;
            end
            PhLoad: begin
              shift_d = word_q[ptr_q];
              ptr_d   = ptr_q + 2'd1;
              bits_d  = 4'd8;
              phase_d = PhClkLo;
            end
            PhClkLo: begin
              pins_d.data = shift_q[0];
              pins_d.sclk = 1'b0;
              phase_d     = PhClkHi;
            end
            PhClkHi: begin
              shift_d     = shift_q >> 1;
              bits_d      = bits_q - 4'd1;
              pins_d.sclk = 1'b1;
              if (bits_d != 4'd0) begin
                phase_d = PhClkLo;
              end else begin
                pins_d.latch = 1'b0;
                phase_d      = PhLatch;
              end
            end
            PhLatch: begin
              pins_d.sclk = 1'b0;
              if (ptr_q == 2'd0) begin
                phase_d = PhBuild;
              end else begin
                if (ptr_q == 2'd3) begin
                  pins_d.latch = 1'b1;
                end
                phase_d = PhLoad;
              end
            end
            default: begin
              pins_d.sclk = 1'b0;
              word_d      = built;
              grid_d      = (g == GridW'(GridCount - 1)) ? '0 : g + GridW'(1);
              phase_d     = PhClear;
            end
          endcase
        end
        vgs_pkg::ModeDigit: begin
          if (32'(in_data_i.position) < GridCount) begin
            digits_d[in_data_i.position[GridW-1:0]] = in_data_i.digit;
          end else begin
            err = 1'b1;
          end
        end
        vgs_pkg::ModeSym: begin
          sym_sel_d[sg[GridW-1:0]]  = vgs_pkg::sym_byte(in_data_i.symbol);
          sym_bits_d[sg[GridW-1:0]] = vgs_pkg::sym_bits(in_data_i.symbol);
        end
        vgs_pkg::ModeBlank: begin
          for (int i = 0; i < GridCount; i++) begin
            digits_d[i]   = vgs_pkg::DigitBlank;
            sym_sel_d[i]  = 2'd0;
            sym_bits_d[i] = 8'h00;
          end
        end
        default: begin
          err = 1'b0;
        end
      endcase
    end
  end

  // Result register: hold until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d       = 1'b1;
      out_d.data_pin    = pins_d.data;
      out_d.shift_clock = pins_d.sclk;
      out_d.latch_clock = pins_d.latch;
      out_d.clear_line  = pins_d.clear;
      out_d.write_error = err;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhBuild;
      for (int i = 0; i < GridCount; i++) begin
        digits_q[i]   <= vgs_pkg::DigitBlank;
        sym_sel_q[i]  <= 2'd0;
        sym_bits_q[i] <= 8'h00;
      end
      word_q      <= {vgs_pkg::ResetTopByte, 8'h00, 8'h00, 8'h00};
      shift_q     <= 8'h00;
      bits_q      <= 4'd0;
      ptr_q       <= 2'd3;
      grid_q      <= '0;
      pins_q      <= '{clear: 1'b1, latch: 1'b0, sclk: 1'b0, data: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      digits_q    <= digits_d;
      sym_sel_q   <= sym_sel_d;
      sym_bits_q  <= sym_bits_d;
      word_q      <= word_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      ptr_q       <= ptr_d;
      grid_q      <= grid_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The clear line never drops once out of reset
  a_clear_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.clear_line)
    else $error("clear line dropped");

  // A digit write to a missing grid reports an error in the next result
  a_bad_pos_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.mode == vgs_pkg::ModeDigit &&
     32'(in_data_i.position) >= GridCount) |=> (out_valid_o && out_data_o.write_error))
    else $error("rejected digit write not flagged");

  // Requests other than a tick leave the sequencer where it was
  a_hold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.mode != vgs_pkg::ModeTick) |=> $stable(phase_q))
    else $error("sequencer moved on a non-tick request");

  // The bit counter never exceeds one byte
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 4'd8)
    else $error("bit counter out of range");

endmodule

`default_nettype wire

// File: rtl/core/vgs_word_build.sv
// Assembles the four-byte shift word for one grid.
`default_nettype none

module vgs_word_build #(
  parameter int unsigned GridCount = vgs_pkg::GridCount,
  localparam int unsigned GridW = $clog2(GridCount)
) (
  input  wire logic [GridW-1:0] grid_i,
  input  wire logic [3:0]       digit_i,
  input  wire logic [1:0]       sym_sel_i,
  input  wire logic [7:0]       sym_bits_i,
  output logic [3:0][7:0]       word_o
);

  logic [3:0] d;
  logic [2:0] g;

  // Clamp digit codes above blank to blank
  assign d = (digit_i > vgs_pkg::DigitBlank) ? vgs_pkg::DigitBlank : digit_i;
  assign g = 3'(grid_i);

  // Segments, then grid select, then symbol bits
  always_comb begin
    word_o    = '0;
    word_o[0] = vgs_pkg::seg_lo(d);
    word_o[1] = vgs_pkg::seg_hi(d);
    word_o[2] = 8'h00;
    word_o[3] = vgs_pkg::WordTopByte;
    word_o[vgs_pkg::grid_byte(g)] = word_o[vgs_pkg::grid_byte(g)] | vgs_pkg::grid_mask(g);
    word_o[sym_sel_i] = word_o[sym_sel_i] | sym_bits_i;
  end

endmodule

`default_nettype wire

// File: verif/tb_vfd_grid_scan_serializer.sv
// Self-checking testbench for the display grid scan serializer: directed, random and stall traffic.
`timescale 1ns / 1ps
`default_nettype none

module tb_vfd_grid_scan_serializer;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned ResetCycles = 12;

  // Segment patterns per digit, index 10 is blank
  localparam logic [10:0][7:0] SegLow  = {8'h00, 8'h6c, 8'h6d, 8'h68, 8'h4d, 8'h4c,
                                          8'h28, 8'h6c, 8'h65, 8'h28, 8'h6d};
  localparam logic [10:0][7:0] SegHigh = {8'h00, 8'ha0, 8'ha0, 8'h00, 8'ha0, 8'ha0,
                                          8'ha0, 8'h20, 8'h20, 8'h00, 8'h80};
  // Grid select bit placement per grid
  localparam logic [6:0][1:0]  GridByte = {2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [6:0][7:0]  GridMask = {8'h10, 8'h02, 8'h40, 8'h10, 8'h01, 8'h20, 8'h04};
  // Symbol placement per symbol index
  localparam logic [7:0][1:0]  SymByte = {2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [7:0][2:0]  SymGrid = {3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd0, 3'd2, 3'd1};
  localparam logic [7:0][7:0]  SymBits = {8'h80, 8'h08, 8'h01, 8'h02,
                                          8'h08, 8'h02, 8'h40, 8'h80};

  typedef enum logic [2:0] {
    ScanBuild = 3'd0,
    ScanClear = 3'd1,
    ScanLoad  = 3'd2,
    ScanClkLo = 3'd3,
    ScanClkHi = 3'd4,
    ScanLatch = 3'd5
  } scan_phase_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  vgs_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  vgs_pkg::out_t out_data_o;

  // Scanner state as predicted
  scan_phase_e    scan_phase;
  logic [3:0]     digit_q [vgs_pkg::GridCount];
  logic [1:0]     sym_sel_q [vgs_pkg::GridCount];
  logic [7:0]     sym_bits_q [vgs_pkg::GridCount];
  logic [7:0]     word_q [4];
  logic [7:0]     shift_q;
  logic [3:0]     bits_left_q;
  logic [1:0]     byte_ptr_q;
  logic [2:0]     grid_q;
  vgs_pkg::pins_t pins_q;

  vgs_pkg::out_t pins_due [$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  vfd_grid_scan_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Clear digits and symbols
  function automatic void blank_grids();
    for (int i = 0; i < vgs_pkg::GridCount; i++) begin
      digit_q[i]    = vgs_pkg::DigitBlank;
      sym_sel_q[i]  = 2'd0;
      sym_bits_q[i] = 8'h00;
    end
  endfunction

  function automatic void reset_scan();
    scan_phase = ScanBuild;
    blank_grids();
    word_q[0]   = 8'h00;
    word_q[1]   = 8'h00;
    word_q[2]   = 8'h00;
    word_q[3]   = vgs_pkg::ResetTopByte;
    shift_q     = 8'h00;
    bits_left_q = 4'd0;
    byte_ptr_q  = 2'd3;
    grid_q      = 3'd0;
    pins_q      = '{clear: 1'b1, default: 1'b0};
  endfunction

  // Apply one beat to the predicted scanner and return the pin levels it leaves
  function automatic vgs_pkg::out_t predict_pins(input vgs_pkg::in_t b);
    vgs_pkg::out_t r;
    logic [2:0]    g;
    logic [3:0]    d;
    r.write_error = 1'b0;
    case (vgs_pkg::mode_e'(b.mode))
      vgs_pkg::ModeTick: begin
        case (scan_phase)
          ScanClear: begin
            pins_q.clear = 1'b1;
            scan_phase = ScanLoad;
          end
          ScanLoad: begin
            shift_q = word_q[byte_ptr_q];
            byte_ptr_q = byte_ptr_q + 2'd1;
            bits_left_q = 4'd8;
            scan_phase = ScanClkLo;
          end
          ScanClkLo: begin
            pins_q.data = shift_q[0];
            pins_q.sclk = 1'b0;
            scan_phase = ScanClkHi;
          end
          ScanClkHi: begin
            shift_q = shift_q >> 1;
            bits_left_q = bits_left_q - 4'd1;
            pins_q.sclk = 1'b1;
            if (bits_left_q != 4'd0) begin
              scan_phase = ScanClkLo;
            end else begin
              pins_q.latch = 1'b0;
              scan_phase = ScanLatch;
            end
          end
          ScanLatch: begin
            pins_q.sclk = 1'b0;
            if (byte_ptr_q == 2'd0) begin
              scan_phase = ScanBuild;
            end else begin
              if (byte_ptr_q == 2'd3) pins_q.latch = 1'b1;
              scan_phase = ScanLoad;
            end
          end
          default: begin
            // Build the next grid word
            g = (grid_q >= vgs_pkg::GridCount) ? 3'd0 : grid_q;
            d = (digit_q[g] > vgs_pkg::DigitBlank) ? vgs_pkg::DigitBlank : digit_q[g];
            pins_q.sclk = 1'b0;
            word_q[0] = SegLow[d];
            word_q[1] = SegHigh[d];
            word_q[2] = 8'h00;
            word_q[3] = vgs_pkg::WordTopByte;
            word_q[GridByte[g]] |= GridMask[g];
            word_q[sym_sel_q[g]] |= sym_bits_q[g];
            grid_q = (g + 3'd1 >= vgs_pkg::GridCount) ? 3'd0 : g + 3'd1;
            scan_phase = ScanClear;
          end
        endcase
      end
      vgs_pkg::ModeDigit: begin
        if (b.position < vgs_pkg::GridCount) digit_q[b.position] = b.digit;
        else r.write_error = 1'b1;
      end
      vgs_pkg::ModeSym: begin
        g = SymGrid[b.symbol];
        sym_sel_q[g]  = SymByte[b.symbol];
        sym_bits_q[g] = SymBits[b.symbol];
      end
      default: blank_grids();
    endcase
    r.data_pin    = pins_q.data;
    r.shift_clock = pins_q.sclk;
    r.latch_clock = pins_q.latch;
    r.clear_line  = pins_q.clear;
    return r;
  endfunction

  function automatic vgs_pkg::in_t make_beat(input vgs_pkg::mode_e m,
                                             input logic [2:0] pos,
                                             input logic [3:0] dig,
                                             input logic [2:0] sym);
    vgs_pkg::in_t b;
    b.mode     = m;
    b.position = pos;
    b.digit    = dig;
    b.symbol   = sym;
    return b;
  endfunction

  // Mostly ticks so the scan runs deep, with writes and rare blanking mixed in
  function automatic vgs_pkg::in_t random_beat();
    int             pick;
    vgs_pkg::mode_e m;
    pick = $urandom_range(0, 99);
    if (pick < 78)      m = vgs_pkg::ModeTick;
    else if (pick < 90) m = vgs_pkg::ModeDigit;
    else if (pick < 98) m = vgs_pkg::ModeSym;
    else                m = vgs_pkg::ModeBlank;
    return make_beat(m, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)));
  endfunction

  // Offer one beat, idling first at random, and hold it until accepted
  task automatic send_beat(input vgs_pkg::in_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Field extremes, every mode, rejected position, large digits
  task automatic test_directed();
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd0, 4'd0, 3'd0));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd6, 4'd15, 3'd7));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd7, 4'd9, 3'd0));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd1, 4'd9, 3'd0));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd3, 4'd10, 3'd0));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd2, 4'd11, 3'd0));
    for (int s = 0; s < 8; s++) send_beat(make_beat(vgs_pkg::ModeSym, 3'd0, 4'd0, 3'(s)));
    for (int t = 0; t < 6; t++) send_beat(make_beat(vgs_pkg::ModeTick, 3'd7, 4'd15, 3'd7));
    send_beat(make_beat(vgs_pkg::ModeBlank, 3'd7, 4'd15, 3'd7));
    send_beat(make_beat(vgs_pkg::ModeDigit, 3'd7, 4'd15, 3'd7));
    for (int t = 0; t < 3; t++) send_beat(make_beat(vgs_pkg::ModeTick, 3'd0, 4'd0, 3'd0));
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) send_beat(random_beat());
  endtask

  // Hold off the sink for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = hold_req + 1;
    repeat (24) send_beat(random_beat());
  endtask

  // Sink ready: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check each result beat, then predict for each accepted input beat
  always @(posedge clk_i) begin : check_results
    vgs_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pins_due.size() == 0) begin
          $display("%0t: unexpected result beat %b", $time, out_data_o);
          fail_count++;
        end else begin
          want = pins_due.pop_front();
          if (want.data_pin    !== out_data_o.data_pin    ||
              want.shift_clock !== out_data_o.shift_clock ||
              want.latch_clock !== out_data_o.latch_clock ||
              want.clear_line  !== out_data_o.clear_line  ||
              want.write_error !== out_data_o.write_error) begin
            $display("%0t: mismatch (data/sclk/latch/clear/err) expected %b actual %b",
                     $time, want, out_data_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) pins_due.push_back(predict_pins(in_data_i));
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("vfd_grid_scan_serializer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_scan();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(0, 0, 420);
    test_random_traffic(48, 0, 420);
    test_random_traffic(0, 48, 420);
    test_random_traffic(36, 36, 420);
    test_output_backpressure();
    in_valid_i <= 1'b0;

    // Drain outstanding results
    @(posedge clk_i);
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("vfd_grid_scan_serializer regression: pass");
    end else begin
      $display("vfd_grid_scan_serializer regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
